[src/ppr_pkg.sv]
package ppr_pkg;

  localparam int NUM_QUEUES_DEF  = 4;
  localparam int QUEUE_BYTES_DEF = 4096;

  localparam int OP_W     = 2;
  localparam int IDX_W    = 3;
  localparam int BYTE_W   = 8;
  localparam int STATUS_W = 3;
  localparam int AIDX_W   = 2;
  localparam int FILL_W   = 13;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC   = 2'd0,
    OP_RELEASE = 2'd1,
    OP_WRITE   = 2'd2,
    OP_READ    = 2'd3
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 3'd0,
    ST_EMPTY  = 3'd1,
    ST_FULL   = 3'd2,
    ST_NOSLOT = 3'd3,
    ST_BADIDX = 3'd4
  } status_t;

  typedef struct packed {
    opcode_t             opcode;
    logic [IDX_W-1:0]    pipe_index;
    logic [BYTE_W-1:0]   write_data;
  } in_t;

  typedef struct packed {
    status_t             status;
    logic [BYTE_W-1:0]   read_data;
    logic [AIDX_W-1:0]   alloc_index;
    logic [FILL_W-1:0]   fill_count;
  } out_t;

  // Result of one item before the byte store answers.
  typedef struct packed {
    status_t             status;
    logic [AIDX_W-1:0]   alloc_index;
    logic [FILL_W-1:0]   fill_count;
    logic                read_hit;
  } info_t;

endpackage

[src/ppr_ram.sv]
module ppr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16384,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic             re,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

[src/ppr_queue_ctrl.sv]
module ppr_queue_ctrl #(
  parameter int NUM_QUEUES  = ppr_pkg::NUM_QUEUES_DEF,
  parameter int QUEUE_BYTES = ppr_pkg::QUEUE_BYTES_DEF,
  localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1,
  localparam int PW = $clog2(QUEUE_BYTES),
  localparam int FW = $clog2(QUEUE_BYTES + 1),
  localparam int AW = ((NUM_QUEUES * QUEUE_BYTES) > 1) ? $clog2(NUM_QUEUES * QUEUE_BYTES) : 1
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       accept,
  input  ppr_pkg::in_t               item,
  output ppr_pkg::info_t             info,
  output logic                       ram_we,
  output logic                       ram_re,
  output logic [AW-1:0]              ram_addr,
  output logic [ppr_pkg::BYTE_W-1:0] ram_wdata
);

  logic [PW-1:0]         rd_ptr [NUM_QUEUES];
  logic [PW-1:0]         wr_ptr [NUM_QUEUES];
  logic [FW-1:0]         fill   [NUM_QUEUES];
  logic [NUM_QUEUES-1:0] busy;

  logic          idx_ok;
  logic [QW-1:0] sel;
  logic          free_found;
  logic [QW-1:0] free_idx;
  logic [FW-1:0] cur_fill;
  logic [PW-1:0] cur_rd;
  logic [PW-1:0] cur_wr;
  logic [PW-1:0] ptr;
  logic          do_alloc;
  logic          do_release;

  assign idx_ok = 32'(item.pipe_index) < 32'(NUM_QUEUES);
  assign sel    = QW'(item.pipe_index);

  assign cur_fill = idx_ok ? fill[sel]   : '0;
  assign cur_rd   = idx_ok ? rd_ptr[sel] : '0;
  assign cur_wr   = idx_ok ? wr_ptr[sel] : '0;

  // Lowest free slot wins.
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = NUM_QUEUES - 1; i >= 0; i--) begin
      if (!busy[i]) begin
        free_found = 1'b1;
        free_idx   = QW'(i);
      end
    end
  end

  always_comb begin
    info       = '0;
    info.status = ppr_pkg::ST_OK;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ptr        = cur_wr;
    do_alloc   = 1'b0;
    do_release = 1'b0;
    if (item.opcode == ppr_pkg::OP_ALLOC) begin
      if (free_found) begin
        do_alloc         = 1'b1;
        info.alloc_index = ppr_pkg::AIDX_W'(free_idx);
      end else begin
        info.status = ppr_pkg::ST_NOSLOT;
      end
    end else if (!idx_ok) begin
      info.status = ppr_pkg::ST_BADIDX;
    end else begin
      case (item.opcode)
        ppr_pkg::OP_RELEASE: begin
          do_release      = 1'b1;
          info.fill_count = ppr_pkg::FILL_W'(cur_fill);
        end
        ppr_pkg::OP_WRITE: begin
          if (32'(cur_fill) >= 32'(QUEUE_BYTES)) begin
            info.status     = ppr_pkg::ST_FULL;
            info.fill_count = ppr_pkg::FILL_W'(cur_fill);
          end else begin
            ram_we          = 1'b1;
            info.fill_count = ppr_pkg::FILL_W'(cur_fill + FW'(1));
          end
        end
        ppr_pkg::OP_READ: begin
          ptr = cur_rd;
          if (cur_fill == '0) begin
            info.status = ppr_pkg::ST_EMPTY;
          end else begin
            ram_re          = 1'b1;
            info.read_hit   = 1'b1;
            info.fill_count = ppr_pkg::FILL_W'(cur_fill - FW'(1));
          end
        end
        default: begin
          info.status = ppr_pkg::ST_BADIDX;
        end
      endcase
    end
    ram_we = ram_we & accept;
    ram_re = ram_re & accept;
  end

  assign ram_addr  = AW'(sel) * AW'(QUEUE_BYTES) + AW'(ptr);
  assign ram_wdata = item.write_data;

  function automatic logic [PW-1:0] step_ptr(input logic [PW-1:0] p);
    logic [PW-1:0] r;
    if (p == PW'(QUEUE_BYTES - 1)) begin
      r = '0;
    end else begin
      r = p + PW'(1);
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= '0;
      for (int i = 0; i < NUM_QUEUES; i++) begin
        rd_ptr[i] <= '0;
        wr_ptr[i] <= '0;
        fill[i]   <= '0;
      end
    end else if (accept) begin
      if (do_alloc) begin
        busy[free_idx]   <= 1'b1;
        rd_ptr[free_idx] <= '0;
        wr_ptr[free_idx] <= '0;
        fill[free_idx]   <= '0;
      end
      if (do_release) begin
        busy[sel] <= 1'b0;
      end
      if (ram_we) begin
        wr_ptr[sel] <= step_ptr(cur_wr);
        fill[sel]   <= cur_fill + FW'(1);
      end
      if (ram_re) begin
        rd_ptr[sel] <= step_ptr(cur_rd);
        fill[sel]   <= cur_fill - FW'(1);
      end
    end
  end

  a_one_access: assert property (@(posedge clk) disable iff (rst)
    !(ram_we && ram_re))
    else $error("write and read of the byte store in one cycle");

  a_busy_hold: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(busy))
    else $error("slot busy bits changed without an item");

  a_alloc_free: assert property (@(posedge clk) disable iff (rst)
    accept && do_alloc |-> !busy[free_idx])
    else $error("allocate granted a busy slot");

endmodule

[src/pipe_pool_ring_fifo.sv]
// Pipeline: read stage (byte store read, s1_info), then output register.
// Throughput: one item per cycle unless out_ready stalls the output; each
// item makes at most one access to the single-port byte store, and the
// per-slot pointers sit in flip-flops.
// Reset clears slot busy bits, pointers, fill levels and the pipeline valids;
// the byte store is not cleared and needs no clearing pass.
module pipe_pool_ring_fifo #(
  parameter int NUM_QUEUES  = ppr_pkg::NUM_QUEUES_DEF,
  parameter int QUEUE_BYTES = ppr_pkg::QUEUE_BYTES_DEF,
  localparam int AW = ((NUM_QUEUES * QUEUE_BYTES) > 1) ? $clog2(NUM_QUEUES * QUEUE_BYTES) : 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  ppr_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output ppr_pkg::out_t out_data
);

  logic                       fire;
  logic                       s1_valid;
  logic                       s1_move;
  ppr_pkg::info_t             s1_info;
  ppr_pkg::info_t             info;
  logic                       ram_we;
  logic                       ram_re;
  logic [AW-1:0]              ram_addr;
  logic [ppr_pkg::BYTE_W-1:0] ram_wdata;
  logic [ppr_pkg::BYTE_W-1:0] ram_rdata;

  // Advance the read stage when the output register is free or draining.
  assign s1_move  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_move;
  assign fire     = in_valid && in_ready;

  ppr_queue_ctrl #(
    .NUM_QUEUES (NUM_QUEUES),
    .QUEUE_BYTES(QUEUE_BYTES)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .accept   (fire),
    .item     (in_data),
    .info     (info),
    .ram_we   (ram_we),
    .ram_re   (ram_re),
    .ram_addr (ram_addr),
    .ram_wdata(ram_wdata)
  );

  ppr_ram #(
    .WIDTH(ppr_pkg::BYTE_W),
    .DEPTH(NUM_QUEUES * QUEUE_BYTES)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .re   (ram_re),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (fire) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      if (s1_move) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
    if (fire) begin
      s1_info <= info;
    end
    if (s1_move) begin
      out_data.status      <= s1_info.status;
      out_data.read_data   <= s1_info.read_hit ? ram_rdata : '0;
      out_data.alloc_index <= s1_info.alloc_index;
      out_data.fill_count  <= s1_info.fill_count;
    end
  end

  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_move |=> s1_valid && $stable(s1_info))
    else $error("read stage lost or changed a stalled item");

  a_no_accept_stalled: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_move |-> !fire)
    else $error("item accepted while the read stage is stalled");

  a_data_only_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.read_data != '0 |-> out_data.status == ppr_pkg::ST_OK)
    else $error("nonzero read data on a failed item");

endmodule

[sim/tb_pipe_pool_ring_fifo.sv]
module tb_pipe_pool_ring_fifo;

  localparam int NQ = ppr_pkg::NUM_QUEUES_DEF;
  localparam int QB = ppr_pkg::QUEUE_BYTES_DEF;
  localparam int PW = $clog2(QB);
  localparam int WATCH_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam int RANDOM_ITEMS = 600;
  localparam int PRINT_CAP = 40;

  // Byte-queue pool: rings, pointers, fill levels and busy bits, plus the
  // results owed by the block in arrival order.
  class pipe_pool_model;
    logic [ppr_pkg::BYTE_W-1:0] ring_mem [NQ*QB];
    logic [PW-1:0]              rd_pos [NQ];
    logic [PW-1:0]              wr_pos [NQ];
    logic [ppr_pkg::FILL_W-1:0] level [NQ];
    bit                         claimed [NQ];
    ppr_pkg::out_t              due_results [$];
    int                         errors;

    function new();
      for (int i = 0; i < NQ; i++) begin
        rd_pos[i] = '0;
        wr_pos[i] = '0;
        level[i] = '0;
        claimed[i] = 1'b0;
      end
      errors = 0;
    endfunction

    function logic [PW-1:0] step_pos(logic [PW-1:0] p);
      return (int'(p) == QB - 1) ? '0 : p + 1'b1;
    endfunction

    function void take_op(ppr_pkg::in_t it);
      ppr_pkg::out_t r;
      int   q;
      int   slot;
      r = '0;
      r.status = ppr_pkg::ST_OK;
      q = int'(it.pipe_index);
      slot = -1;
      if (it.opcode == ppr_pkg::OP_ALLOC) begin
        for (int i = 0; i < NQ; i++)
          if (!claimed[i] && slot < 0) slot = i;
        if (slot < 0) begin
          r.status = ppr_pkg::ST_NOSLOT;
        end else begin
          claimed[slot] = 1'b1;
          rd_pos[slot] = '0;
          wr_pos[slot] = '0;
          level[slot] = '0;
          r.alloc_index = slot[ppr_pkg::AIDX_W-1:0];
        end
      end else if (q >= NQ) begin
        r.status = ppr_pkg::ST_BADIDX;
      end else if (it.opcode == ppr_pkg::OP_RELEASE) begin
        claimed[q] = 1'b0;
        r.fill_count = level[q];
      end else if (it.opcode == ppr_pkg::OP_WRITE) begin
        if (int'(level[q]) >= QB) begin
          r.status = ppr_pkg::ST_FULL;
        end else begin
          ring_mem[q*QB + int'(wr_pos[q])] = it.write_data;
          wr_pos[q] = step_pos(wr_pos[q]);
          level[q] = level[q] + 1'b1;
        end
        r.fill_count = level[q];
      end else begin
        if (level[q] == 0) begin
          r.status = ppr_pkg::ST_EMPTY;
        end else begin
          r.read_data = ring_mem[q*QB + int'(rd_pos[q])];
          rd_pos[q] = step_pos(rd_pos[q]);
          level[q] = level[q] - 1'b1;
        end
        r.fill_count = level[q];
      end
      due_results.push_back(r);
    endfunction

    task report(string what);
      errors++;
      if (errors <= PRINT_CAP) $display("mismatch: %s", what);
    endtask

    task match_result(ppr_pkg::out_t got);
      ppr_pkg::out_t want;
      if (due_results.size() == 0) begin
        report($sformatf("result %h with no item outstanding", got));
        return;
      end
      want = due_results.pop_front();
      if (got.status !== want.status)
        report($sformatf("status got %0d want %0d", got.status, want.status));
      if (got.read_data !== want.read_data)
        report($sformatf("read_data got %h want %h", got.read_data, want.read_data));
      if (got.alloc_index !== want.alloc_index)
        report($sformatf("alloc_index got %0d want %0d", got.alloc_index,
                         want.alloc_index));
      if (got.fill_count !== want.fill_count)
        report($sformatf("fill_count got %0d want %0d", got.fill_count,
                         want.fill_count));
    endtask
  endclass

  logic          clk;
  logic          rst;
  logic          in_valid;
  logic          in_ready;
  ppr_pkg::in_t  in_data;
  logic          out_valid;
  logic          out_ready;
  ppr_pkg::out_t out_data;

  pipe_pool_model pool;
  int idle_cycles;

  pipe_pool_ring_fifo dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  always #1 clk = ~clk;

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic push_op(ppr_pkg::opcode_t op, int idx, int data, bit brisk);
    ppr_pkg::in_t it;
    int  gap;
    it.opcode = op;
    it.pipe_index = idx[ppr_pkg::IDX_W-1:0];
    it.write_data = data[ppr_pkg::BYTE_W-1:0];
    if (brisk) gap = ($urandom_range(0, 49) == 0) ? $urandom_range(1, 20) : 0;
    else gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    pool.take_op(it);
  endtask

  task automatic put_byte(int q, bit brisk);
    push_op(ppr_pkg::OP_WRITE, q, $urandom_range(0, 255), brisk);
  endtask

  task automatic get_byte(int q, bit brisk);
    push_op(ppr_pkg::OP_READ, q, $urandom_range(0, 255), brisk);
  endtask

  // Result side: random stalls, with long stretches of steady ready.
  initial begin : result_sink
    int stall;
    int run;
    forever begin
      stall = pick_gap();
      if (stall > 0) begin
        @(negedge clk);
        out_ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk);
      out_ready <= 1'b1;
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 400) : $urandom_range(1, 8);
      repeat (run - 1) @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (out_valid && out_ready) pool.match_result(out_data);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WATCH_LIMIT) begin
        $display("tb_pipe_pool_ring_fifo: errors");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    int n;
    int pick;
    int q;
    int k;
    int m;
    clk = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    pool = new();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Free-slot access, out-of-range indexes, release of a free slot.
    push_op(ppr_pkg::OP_READ, 0, 8'h00, 1'b0);
    push_op(ppr_pkg::OP_WRITE, 5, 8'hFF, 1'b0);
    push_op(ppr_pkg::OP_READ, 7, 8'h00, 1'b0);
    push_op(ppr_pkg::OP_RELEASE, 4, 8'h00, 1'b0);
    push_op(ppr_pkg::OP_RELEASE, 2, 8'h00, 1'b0);
    // Claim every slot, then one more.
    push_op(ppr_pkg::OP_ALLOC, 7, 8'h00, 1'b0);
    push_op(ppr_pkg::OP_ALLOC, 0, 8'h00, 1'b0);
    push_op(ppr_pkg::OP_ALLOC, 3, 8'h00, 1'b0);
    push_op(ppr_pkg::OP_ALLOC, 0, 8'h00, 1'b0);
    push_op(ppr_pkg::OP_ALLOC, 1, 8'h00, 1'b0);
    push_op(ppr_pkg::OP_WRITE, 0, 8'h00, 1'b0);
    push_op(ppr_pkg::OP_WRITE, 0, 8'hFF, 1'b0);
    push_op(ppr_pkg::OP_WRITE, 3, 8'hA5, 1'b0);
    push_op(ppr_pkg::OP_READ, 0, 8'h00, 1'b0);
    push_op(ppr_pkg::OP_READ, 0, 8'h00, 1'b0);
    push_op(ppr_pkg::OP_READ, 0, 8'h00, 1'b0);
    push_op(ppr_pkg::OP_READ, 3, 8'h00, 1'b0);
    // Release with data held, reclaim clears it.
    push_op(ppr_pkg::OP_WRITE, 2, 8'h5A, 1'b0);
    push_op(ppr_pkg::OP_RELEASE, 2, 8'h00, 1'b0);
    push_op(ppr_pkg::OP_RELEASE, 1, 8'h00, 1'b0);
    push_op(ppr_pkg::OP_ALLOC, 6, 8'h00, 1'b0);
    push_op(ppr_pkg::OP_ALLOC, 2, 8'h00, 1'b0);
    push_op(ppr_pkg::OP_READ, 2, 8'h00, 1'b0);

    // Offset the pointers of slot 0, fill it to the top, overflow, drain
    // across the wrap and underflow.
    repeat (100) begin
      put_byte(0, 1'b1);
      get_byte(0, 1'b1);
    end
    repeat (QB) put_byte(0, 1'b1);
    repeat (2) put_byte(0, 1'b0);
    repeat (QB) get_byte(0, 1'b1);
    get_byte(0, 1'b0);

    n = 0;
    while (n < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        q = $urandom_range(0, NQ - 1);
        k = $urandom_range(1, 10);
        m = $urandom_range(1, k + 2);
        repeat (k) put_byte(q, 1'b0);
        repeat (m) get_byte(q, 1'b0);
        n += k + m;
      end else if (pick < 70) begin
        push_op(ppr_pkg::OP_RELEASE, $urandom_range(0, NQ - 1),
                $urandom_range(0, 255), 1'b0);
        push_op(ppr_pkg::OP_ALLOC, $urandom_range(0, 7), $urandom_range(0, 255), 1'b0);
        n += 2;
      end else begin
        q = ($urandom_range(0, 5) == 0) ? $urandom_range(NQ, 7) : $urandom_range(0, NQ - 1);
        push_op(ppr_pkg::opcode_t'(2'($urandom_range(0, 3))), q,
                $urandom_range(0, 255), 1'b0);
        n++;
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (pool.due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pool.errors == 0) $display("tb_pipe_pool_ring_fifo: clean");
    else $display("tb_pipe_pool_ring_fifo: errors");
    $finish;
  end

endmodule
